// ===== rtl/rcs_pkg.sv =====
package rcs_pkg;

	// Value format
	localparam int VW = 32;
	// Divisor: 2*RC + H fits in 50 bits
	localparam int DW = 50;
	// Numerator magnitude width
	localparam int NW = 96;
	// Coefficient (signed) width
	localparam int AW = 51;
	// Config register width
	localparam int CW = 24;

	typedef enum logic [1:0] {
		METH_FWD  = 2'd0,
		METH_BWD  = 2'd1,
		METH_TRAP = 2'd2,
		METH_HOLD = 2'd3
	} meth_t;

	typedef enum logic [1:0] {
		CFG_METHOD = 2'd0,
		CFG_RES    = 2'd1,
		CFG_CAP    = 2'd2,
		CFG_STEP   = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/rc_series_circuit_step_unit.sv =====
// Series RC step unit, shift-add multiplier and restoring divider shared over two values.
// Per value: two multiply-adds (51 multiplier bits) and one divide (96 quotient bits); the
// result is then committed from ST_OUT.
// One item in flight; a new sample is taken only in ST_IDLE. A finished item waits in
// ST_OUT while the output register still holds a result not yet taken.
// Reset (arst_n low): state to zero, method 0, R=1000, C=1000000 pF, h=1000 ns.
module rc_series_circuit_step_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [rcs_pkg::CW-1:0]       cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [rcs_pkg::VW-1:0] source_voltage,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [rcs_pkg::VW-1:0] capacitor_voltage,
	output logic signed [rcs_pkg::VW-1:0] resistor_current
);
	localparam int AW = rcs_pkg::AW;
	localparam int NW = rcs_pkg::NW;

	rcs_pkg::state_t state_q, state_d;
	logic [1:0]              meth_q;
	logic [rcs_pkg::CW-1:0]  res_q, cap_q, stp_q;
	logic signed [rcs_pkg::VW-1:0] last_q, vc_q, cur_q, vin_q;
	logic [1:0]              phase_q;
	logic                    sel_q;
	logic signed [NW:0]      acc_q;
	logic signed [rcs_pkg::VW-1:0] vc_out_q, cur_out_q;
	logic                    oval_q;

	// Coefficients, computed from registers (narrow products kept in one stage)
	logic [rcs_pkg::CW-1:0]  r_e, c_e, h_e;
	logic [47:0]             rc;
	logic [33:0]             h;
	logic [33:0]             k;
	logic signed [AW-1:0]    coef_a, coef_bv_m, coef_bi_m;
	logic signed [AW-1:0]    bv_x, bi_x;
	logic [rcs_pkg::DW-1:0]  den;
	logic signed [rcs_pkg::VW:0] dv, sp;

	always_comb begin
		r_e = (res_q == '0) ? rcs_pkg::CW'(1) : res_q;
		c_e = (cap_q == '0) ? rcs_pkg::CW'(1) : cap_q;
		h_e = (stp_q == '0) ? rcs_pkg::CW'(1) : stp_q;
		rc  = 48'(r_e) * 48'(c_e);
		h   = 34'(h_e) * 34'd1000;
		k   = 34'(c_e) * 34'd1000;
		dv  = (rcs_pkg::VW+1)'(vin_q) - (rcs_pkg::VW+1)'(last_q);
		sp  = (rcs_pkg::VW+1)'(vin_q) + (rcs_pkg::VW+1)'(last_q);
		unique case (rcs_pkg::meth_t'(meth_q))
			rcs_pkg::METH_FWD: begin
				coef_a = AW'(rc) - AW'(h);
				den = rcs_pkg::DW'(rc);
				coef_bv_m = AW'(h); bv_x = AW'(last_q);
				coef_bi_m = AW'(k); bi_x = AW'(dv);
			end
			rcs_pkg::METH_BWD: begin
				coef_a = AW'(rc);
				den = rcs_pkg::DW'(rc) + rcs_pkg::DW'(h);
				coef_bv_m = AW'(h); bv_x = AW'(vin_q);
				coef_bi_m = AW'(k); bi_x = AW'(dv);
			end
			rcs_pkg::METH_TRAP: begin
				coef_a = (AW'(rc) <<< 1) - AW'(h);
				den = (rcs_pkg::DW'(rc) << 1) + rcs_pkg::DW'(h);
				coef_bv_m = AW'(h); bv_x = AW'(sp);
				coef_bi_m = AW'(k) <<< 1; bi_x = AW'(dv);
			end
			default: begin
				coef_a = '0; den = rcs_pkg::DW'(1);
				coef_bv_m = '0; bv_x = '0;
				coef_bi_m = '0; bi_x = '0;
			end
		endcase
	end

	// Multiplier operand select: phase 0 bias term, phase 1 state term
	logic                 mac_start, mac_done, div_start, div_done;
	logic signed [AW-1:0] ma, mb;
	logic signed [NW:0]   mc, mac_acc;
	logic [rcs_pkg::VW-1:0] quo;

	always_comb begin
		if (phase_q == 2'd0) begin
			ma = sel_q ? coef_bi_m : coef_bv_m;
			mb = sel_q ? bi_x : bv_x;
			mc = '0;
		end else begin
			ma = coef_a;
			mb = sel_q ? AW'(cur_q) : AW'(vc_q);
			mc = acc_q;
		end
	end

	rcs_serial_mac u_mac (
		.clk(clk), .arst_n(arst_n), .start(mac_start),
		.a(ma), .b(mb), .c(mc), .done(mac_done), .acc(mac_acc)
	);

	rcs_serial_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(acc_q), .den(den), .done(div_done), .quo(quo)
	);

	// Control
	logic kick_q;
	always_comb begin
		state_d   = state_q;
		mac_start = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			rcs_pkg::ST_IDLE: if (in_valid && in_ready) state_d = rcs_pkg::ST_MUL;
			rcs_pkg::ST_MUL: begin
				mac_start = kick_q;
				if (mac_done && phase_q == 2'd1) state_d = rcs_pkg::ST_DIV;
			end
			rcs_pkg::ST_DIV: begin
				div_start = kick_q;
				if (div_done) state_d = sel_q ? rcs_pkg::ST_OUT : rcs_pkg::ST_MUL;
			end
			rcs_pkg::ST_OUT: if (!oval_q) state_d = rcs_pkg::ST_IDLE;
			default: state_d = rcs_pkg::ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == rcs_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcs_pkg::ST_IDLE;
			meth_q  <= 2'd0;
			res_q   <= rcs_pkg::CW'(1000);
			cap_q   <= rcs_pkg::CW'(1000000);
			stp_q   <= rcs_pkg::CW'(1000);
			last_q  <= '0;
			vc_q    <= '0;
			cur_q   <= '0;
			oval_q  <= 1'b0;
			phase_q <= 2'd0;
			sel_q   <= 1'b0;
			kick_q  <= 1'b0;
			capacitor_voltage <= '0;
			resistor_current  <= '0;
		end else begin
			state_q <= state_d;
			// Start pulse for the next serial unit
			kick_q  <= (state_q == rcs_pkg::ST_IDLE && in_valid && in_ready) ||
				(state_q == rcs_pkg::ST_MUL && mac_done) ||
				(state_q == rcs_pkg::ST_DIV && div_done && !sel_q);
			if (cfg_we) begin
				unique case (rcs_pkg::cfg_idx_t'(cfg_index))
					rcs_pkg::CFG_METHOD: meth_q <= cfg_data[1:0];
					rcs_pkg::CFG_RES:    res_q  <= cfg_data;
					rcs_pkg::CFG_CAP:    cap_q  <= cfg_data;
					rcs_pkg::CFG_STEP:   stp_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) oval_q <= 1'b0;
			unique case (state_q)
				rcs_pkg::ST_IDLE: if (in_valid && in_ready) begin
					phase_q <= 2'd0;
					sel_q   <= 1'b0;
				end
				rcs_pkg::ST_MUL: if (mac_done) begin
					if (phase_q == 2'd0) phase_q <= 2'd1;
				end
				rcs_pkg::ST_DIV: if (div_done) begin
					if (!sel_q) begin
						sel_q   <= 1'b1;
						phase_q <= 2'd0;
					end
				end
				// Commit once the output register is free
				rcs_pkg::ST_OUT: if (!oval_q) begin
					if (meth_q != rcs_pkg::METH_HOLD) begin
						vc_q  <= vc_out_q;
						cur_q <= cur_out_q;
						capacitor_voltage <= vc_out_q;
						resistor_current  <= cur_out_q;
					end else begin
						capacitor_voltage <= vc_q;
						resistor_current  <= cur_q;
					end
					last_q <= vin_q;
					oval_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == rcs_pkg::ST_IDLE && in_valid && in_ready) vin_q <= source_voltage;
		if (mac_done) acc_q <= mac_acc;
		if (div_done) begin
			if (sel_q) cur_out_q <= quo;
			else vc_out_q <= quo;
		end
	end

	assign out_valid = oval_q;

	// Checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rcs_pkg::ST_IDLE) |-> !in_ready) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(capacitor_voltage)))
		else $error("result dropped");
	a_div_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == rcs_pkg::ST_DIV)) else $error("divide out of order");
endmodule

// ===== rtl/rcs_serial_mac.sv =====
// Bit-serial signed multiply-accumulate: acc = a*b + c, one multiplier bit per cycle.
module rcs_serial_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [rcs_pkg::AW-1:0] a,
	input  logic signed [rcs_pkg::AW-1:0] b,
	input  logic signed [rcs_pkg::NW:0]   c,
	output logic                        done,
	output logic signed [rcs_pkg::NW:0]   acc
);
	localparam int CNTW = $clog2(rcs_pkg::AW + 1);

	logic signed [rcs_pkg::NW:0]   acc_q;
	logic signed [rcs_pkg::NW:0]   mcand_q;
	logic        [rcs_pkg::AW-1:0] mplier_q;
	logic        [CNTW-1:0]        cnt_q;
	logic                          busy_q;
	logic                          done_q;

	// Step counter; done pulses the cycle after the last step, with acc final
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNTW'(rcs_pkg::AW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(rcs_pkg::AW - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// Shift-add over multiplier bits; top bit carries negative weight
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= c;
			mcand_q  <= (rcs_pkg::NW+1)'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				if (cnt_q == CNTW'(rcs_pkg::AW - 1))
					acc_q <= acc_q - mcand_q;
				else
					acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;
endmodule

// ===== rtl/rcs_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, with rounding and saturation.
module rcs_serial_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [rcs_pkg::NW:0]   num,
	input  logic [rcs_pkg::DW-1:0]        den,
	output logic                        done,
	output logic [rcs_pkg::VW-1:0]        quo
);
	localparam int CNTW = $clog2(rcs_pkg::NW + 1);

	logic [rcs_pkg::NW-1:0] n_q;
	logic [rcs_pkg::NW-1:0] q_q;
	logic [rcs_pkg::DW:0]   r_q;
	logic [rcs_pkg::DW-1:0] d_q;
	logic                   neg_q;
	logic                   busy_q;
	logic                   done_q;
	logic [CNTW-1:0]        cnt_q;
	logic [rcs_pkg::NW:0]   mag;
	logic [rcs_pkg::DW:0]   r_sh;
	logic [rcs_pkg::VW-1:0] lim;

	// Magnitude plus half divisor (fits: |num| < 2^95)
	always_comb begin
		mag  = num[rcs_pkg::NW] ? -num : num;
		mag  = mag + (rcs_pkg::NW+1)'(den >> 1);
		r_sh = {r_q[rcs_pkg::DW-1:0], n_q[rcs_pkg::NW-1]};
		lim  = {1'b0, {(rcs_pkg::VW-1){1'b1}}} + rcs_pkg::VW'(neg_q);
	end

	// Step counter; done pulses the cycle after the last quotient bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNTW'(rcs_pkg::NW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(rcs_pkg::NW - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= mag[rcs_pkg::NW-1:0];
			q_q   <= '0;
			r_q   <= '0;
			d_q   <= den;
			neg_q <= num[rcs_pkg::NW];
		end else if (busy_q) begin
			n_q <= n_q << 1;
			if (r_sh >= {1'b0, d_q}) begin
				r_q <= r_sh - {1'b0, d_q};
				q_q <= {q_q[rcs_pkg::NW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[rcs_pkg::NW-2:0], 1'b0};
			end
		end
	end

	// Saturate magnitude, then restore sign
	always_comb begin
		if (q_q[rcs_pkg::NW-1:rcs_pkg::VW] != '0 || q_q[rcs_pkg::VW-1:0] > lim)
			quo = neg_q ? -lim : lim;
		else
			quo = neg_q ? -q_q[rcs_pkg::VW-1:0] : q_q[rcs_pkg::VW-1:0];
	end

	assign done = done_q;
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int  LIMIT_CYCLES   = 6000000;
	localparam int  DRAIN_CYCLES   = 400;
	localparam int  HOLDOFF_CYCLES = 3000;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [1:0]                    cfg_index;
	logic [rcs_pkg::CW-1:0]        cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [rcs_pkg::VW-1:0] source_voltage;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [rcs_pkg::VW-1:0] capacitor_voltage;
	logic signed [rcs_pkg::VW-1:0] resistor_current;

	typedef struct packed {
		logic signed [rcs_pkg::VW-1:0] vcap;
		logic signed [rcs_pkg::VW-1:0] iamp;
	} step_result_t;

	step_result_t          expected_steps[$];
	int                    errors = 0;
	longint                cycles = 0;
	bit                    steady = 0;     // no idling on either side
	int                    hold_reqs = 0;  // receiver hold-off requests
	int                    hold_seen = 0;  // requests taken by the receiver
	int                    holdoff = 0;    // receiver hold-off cycles left

	// circuit state mirror
	rcs_pkg::meth_t                m_method = rcs_pkg::METH_FWD;
	logic [rcs_pkg::CW-1:0]        m_res  = 1000;
	logic [rcs_pkg::CW-1:0]        m_cap  = 1000000;
	logic [rcs_pkg::CW-1:0]        m_step = 1000;
	logic signed [rcs_pkg::VW-1:0] m_last_vs = '0;
	logic signed [rcs_pkg::VW-1:0] m_vcap = '0;
	logic signed [rcs_pkg::VW-1:0] m_iamp = '0;

	rc_series_circuit_step_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .source_voltage(source_voltage),
		.out_valid(out_valid), .out_ready(out_ready),
		.capacitor_voltage(capacitor_voltage), .resistor_current(resistor_current)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// rounded (ties away from zero), saturated division; d > 0
	function automatic logic signed [rcs_pkg::VW-1:0] div_sat(logic signed [127:0] n,
		logic [127:0] d);
		logic         neg;
		logic [127:0] mag, q, lim;
		neg = n[127];
		mag = neg ? -n : n;
		mag = mag + (d >> 1);
		q   = mag / d;
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (q > lim) q = lim;
		return neg ? -q[rcs_pkg::VW-1:0] : q[rcs_pkg::VW-1:0];
	endfunction

	// advance the circuit mirror by one source sample
	function automatic step_result_t advance_circuit(logic signed [rcs_pkg::VW-1:0] vs);
		logic signed [127:0] r, c, h, rc, k, a, bv, bi, d, ws, wp, wv, wi, dv;
		step_result_t        res;
		r  = (m_res  != 0) ? m_res  : 1;
		c  = (m_cap  != 0) ? m_cap  : 1;
		h  = ((m_step != 0) ? m_step : 1) * 1000;
		rc = r * c;
		k  = c * 1000;
		ws = vs; wp = m_last_vs; wv = m_vcap; wi = m_iamp;
		dv = ws - wp;
		case (m_method)
			rcs_pkg::METH_FWD: begin
				a = rc - h; d = rc; bv = h * wp; bi = k * dv;
			end
			rcs_pkg::METH_BWD: begin
				a = rc; d = rc + h; bv = h * ws; bi = k * dv;
			end
			rcs_pkg::METH_TRAP: begin
				a = 2 * rc - h; d = 2 * rc + h; bv = h * (ws + wp); bi = 2 * k * dv;
			end
			default: begin
				a = 0; d = 1; bv = 0; bi = 0;
			end
		endcase
		if (m_method != rcs_pkg::METH_HOLD) begin
			m_vcap = div_sat(a * wv + bv, d);
			m_iamp = div_sat(a * wi + bi, d);
		end
		m_last_vs = vs;
		res.vcap = m_vcap;
		res.iamp = m_iamp;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [rcs_pkg::VW-1:0] exp_v,
		logic [rcs_pkg::VW-1:0] got_v);
		$display("MISMATCH %s: expected %h got %h (cycle %0d)", what, exp_v, got_v, cycles);
		errors++;
	endtask

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout at cycle %0d", cycles);
			$display("** rc_series_circuit_step_unit: FAILED **");
			$finish;
		end
	end

	// predict on each accepted sample
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			expected_steps.push_back(advance_circuit(source_voltage));
	end

	// compare each accepted result
	always @(posedge clk) begin
		step_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_steps.size() == 0) begin
				report_mismatch("unexpected result", '0, capacitor_voltage);
			end else begin
				e = expected_steps.pop_front();
				if (capacitor_voltage !== e.vcap)
					report_mismatch("capacitor_voltage", e.vcap, capacitor_voltage);
				if (resistor_current !== e.iamp)
					report_mismatch("resistor_current", e.iamp, resistor_current);
			end
		end
	end

	// receiver: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			holdoff   <= HOLDOFF_CYCLES;
			out_ready <= 1'b0;
		end else if (holdoff > 0) begin
			out_ready <= 1'b0;
			holdoff   <= holdoff - 1;
		end else begin
			out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
		end
	end

	task automatic send_sample(logic signed [rcs_pkg::VW-1:0] v);
		if (!steady && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < 33) @(posedge clk);
		end
		in_valid       <= 1'b1;
		source_voltage <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_steps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(rcs_pkg::cfg_idx_t idx, logic [rcs_pkg::CW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			rcs_pkg::CFG_METHOD: m_method = rcs_pkg::meth_t'(val[1:0]);
			rcs_pkg::CFG_RES:    m_res    = val;
			rcs_pkg::CFG_CAP:    m_cap    = val;
			default:             m_step   = val;
		endcase
	endtask

	task automatic set_circuit(rcs_pkg::meth_t meth, logic [rcs_pkg::CW-1:0] r,
		logic [rcs_pkg::CW-1:0] c, logic [rcs_pkg::CW-1:0] h);
		wait_drained();
		write_reg(rcs_pkg::CFG_METHOD, rcs_pkg::CW'(meth));
		write_reg(rcs_pkg::CFG_RES, r);
		write_reg(rcs_pkg::CFG_CAP, c);
		write_reg(rcs_pkg::CFG_STEP, h);
	endtask

	function automatic logic signed [rcs_pkg::VW-1:0] rand_voltage();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return rcs_pkg::VW'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
			2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return rcs_pkg::VW'($signed($urandom_range(0, 400)) - 200);
		endcase
	endfunction

	function automatic logic [rcs_pkg::CW-1:0] rand_reg();
		case ($urandom_range(0, 4))
			0: return 24'hff_ffff;
			1: return rcs_pkg::CW'($urandom_range(0, 3));
			2: return rcs_pkg::CW'($urandom_range(1, 5000));
			default: return rcs_pkg::CW'($urandom);
		endcase
	endfunction

	// extremes of the input, each method at reset settings, and register corner cases
	task automatic test_directed();
		logic signed [rcs_pkg::VW-1:0] edge_vals[6] =
			'{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 1, 32'sh0001_0000};
		foreach (edge_vals[i]) send_sample(edge_vals[i]);
		for (int m = 0; m < 4; m++) begin
			set_circuit(rcs_pkg::meth_t'(m), 1000, 1000000, 1000);
			send_sample(32'sh000a_0000);
			send_sample(32'sh8000_0000);
			send_sample(32'sh7fff_ffff);
		end
		// zero registers act as one
		set_circuit(rcs_pkg::METH_BWD, 0, 0, 0);
		send_sample(32'sh7fff_ffff);
		send_sample(32'sh8000_0000);
		// unstable forward step saturates
		set_circuit(rcs_pkg::METH_FWD, 1, 1, 24'hff_ffff);
		send_sample(32'sh7fff_ffff);
		send_sample(32'sh8000_0000);
		send_sample(32'sh0100_0000);
		// largest registers
		set_circuit(rcs_pkg::METH_TRAP, 24'hff_ffff, 24'hff_ffff, 24'hff_ffff);
		send_sample(32'sh7fff_ffff);
		send_sample(32'sh8000_0000);
	endtask

	// random samples over a sweep of circuit settings
	task automatic test_random_sweep();
		for (int p = 0; p < 10; p++) begin
			if (p < 4)
				set_circuit(rcs_pkg::meth_t'(p), rand_reg(), rand_reg(), rand_reg());
			else
				set_circuit(rcs_pkg::meth_t'($urandom_range(0, 3)), rand_reg(), rand_reg(),
					rand_reg());
			steady = (p == 5);
			for (int i = 0; i < 160; i++) send_sample(rand_voltage());
			steady = 0;
		end
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		set_circuit(rcs_pkg::METH_TRAP, 1000, 1000000, 1000);
		hold_reqs++;
		for (int i = 0; i < 30; i++) send_sample(rand_voltage());
		// sender pauses until everything has come back
		wait_drained();
		for (int i = 0; i < 30; i++) send_sample(rand_voltage());
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		source_voltage = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random_sweep();

		wait_drained();
		if (errors == 0)
			$display("** rc_series_circuit_step_unit: PASSED **");
		else
			$display("** rc_series_circuit_step_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rcs_pkg.sv
rtl/rcs_serial_mac.sv
rtl/rcs_serial_div.sv
rtl/rc_series_circuit_step_unit.sv
tb/tb_top.sv
